FILE: src/cpu_utilization_meter_macros.svh
// Assertion macros shared by the processor utilization meter RTL.
`ifndef CPU_UTILIZATION_METER_MACROS_SVH
`define CPU_UTILIZATION_METER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CUM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CUM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cpu_um_pkg.sv
// Types, constants and helpers of the processor utilization meter.
`timescale 1ns / 1ps

package cpu_um_pkg;

  localparam int NUM_SLOTS    = 5;
  localparam int SLOT_W       = 3;
  localparam int SLOT_IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CTR_W        = 64;
  localparam int NUM_CTRS     = 8;
  localparam int IDLE_CTR     = 3;
  localparam int Q_W          = 10;
  localparam int PROD_W       = CTR_W + Q_W;
  localparam int CNT_W        = $clog2(PROD_W);
  localparam int COL_W        = 4;
  localparam int USAGE_W      = 10;
  localparam int BAR_W        = 4;
  localparam int BAR_SEGMENTS = 8;

  localparam logic [SLOT_W:0]  NUM_SLOTS_C = (SLOT_W + 1)'(NUM_SLOTS);
  localparam logic [Q_W-1:0]   PER_MILLE   = 10'd1000;
  localparam logic [USAGE_W-1:0] ROUND_ADD = 10'd5;
  localparam logic [USAGE_W-1:0] BAR_STEP  = 10'd125;

  typedef struct packed {
    logic [SLOT_W-1:0] cpu_slot;
    logic [CTR_W-1:0]  user_time;
    logic [CTR_W-1:0]  nice_time;
    logic [CTR_W-1:0]  system_time;
    logic [CTR_W-1:0]  idle_time;
    logic [CTR_W-1:0]  iowait_time;
    logic [CTR_W-1:0]  irq_time;
    logic [CTR_W-1:0]  softirq_time;
    logic [CTR_W-1:0]  steal_time;
  } sample_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_out;
    logic [USAGE_W-1:0] usage_tenths;
    logic [BAR_W-1:0]   bar_level;
    logic               no_time_error;
  } result_t;

  // Number of segment thresholds (0, 12.5% ... 87.5%) that usage exceeds.
  function automatic logic [BAR_W-1:0] bar_of(input logic [USAGE_W-1:0] usage);
    logic [BAR_W-1:0] n;
    n = '0;
    for (int i = 0; i < BAR_SEGMENTS; i++) begin
      if (usage > USAGE_W'(i * int'(BAR_STEP))) begin
        n = n + BAR_W'(1);
      end
    end
    return n;
  endfunction

endpackage

FILE: src/cpu_utilization_meter.sv
// Processor utilization meter: bit-serial counter deltas and busy per-mille.
`timescale 1ns / 1ps

// Takes one slot's eight cumulative tick counters per item and returns usage
// in tenths of a percent (busy per-mille plus 5), an eight-step bar level and
// a flag for a zero total delta. An item runs from acceptance through the
// bit-serial pass, which sums the counters, forms the idle and total deltas
// against the slot's stored values and multiplies the busy delta by 1000 one
// bit per cycle, then through restoring division (one quotient bit per cycle
// on a 64-bit remainder), then the load of the output register. The next item
// is taken the cycle after that load; a full output register that is stalled
// holds the load back until it drains.
// One item is in work at a time; a finished result waits in the output
// register while the next item runs.
// Slots at or above the slot count use zero history and store nothing.
module cpu_utilization_meter (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  cpu_um_pkg::sample_t sample,
  output logic               result_valid,
  input  logic               result_stall,
  output cpu_um_pkg::result_t result
);
  import cpu_um_pkg::*;

`include "cpu_utilization_meter_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DIV, ST_DONE} state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [SLOT_W-1:0]   slot;
  logic                in_range;
  logic [CTR_W-1:0]    ctr [NUM_CTRS];
  logic [CTR_W-1:0]    old_idle;
  logic [CTR_W-1:0]    old_total;
  logic [CTR_W-1:0]    total_sr;
  logic [CTR_W-1:0]    den_sr;
  logic [PROD_W-1:0]   prod;
  logic [CTR_W-1:0]    rem;
  logic [Q_W-1:0]      qsh;
  logic [COL_W-2:0]    sum_c;
  logic [COL_W-2:0]    mul_c;
  logic                idle_b;
  logic                tot_b;
  logic                busy_b;
  logic [Q_W-2:0]      hist;
  logic                nz;
  logic [CTR_W-1:0]    last_idle  [NUM_SLOTS];
  logic [CTR_W-1:0]    last_total [NUM_SLOTS];

  logic                accept;
  logic                active;
  logic [COL_W-1:0]    col;
  logic                tb;
  logic                ib, pib, pt;
  logic                di, dt, bb;
  logic                idle_b_next, tot_b_next, busy_b_next;
  logic [COL_W-1:0]    msum;
  logic [SLOT_IDX_W-1:0] idx;
  logic                slot_ok;
  logic [CTR_W:0]      r2;
  logic [CTR_W:0]      rsub;
  logic                dge;
  logic [USAGE_W-1:0]  usage;
  logic                out_free;
  logic                err_zeroed;
  logic                usage_ok;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != ST_IDLE);
  assign out_free     = !result_valid || !result_stall;
  assign idx          = sample.cpu_slot[SLOT_IDX_W-1:0];
  assign slot_ok      = {1'b0, sample.cpu_slot} < NUM_SLOTS_C;
  assign active       = cnt < CNT_W'(CTR_W);

  // One bit column of the counter sum, both deltas and the busy delta.
  always_comb begin
    col = {1'b0, sum_c};
    for (int i = 0; i < NUM_CTRS; i++) begin
      col = col + COL_W'(ctr[i][0]);
    end
    tb  = col[0];
    ib  = ctr[IDLE_CTR][0];
    pib = old_idle[0];
    pt  = old_total[0];
    di  = ib ^ pib ^ idle_b;
    idle_b_next = (~ib & pib) | (~(ib ^ pib) & idle_b);
    dt  = tb ^ pt ^ tot_b;
    tot_b_next = (~tb & pt) | (~(tb ^ pt) & tot_b);
    bb  = active & (dt ^ di ^ busy_b);
    busy_b_next = (~dt & di) | (~(dt ^ di) & busy_b);
  end

  // Bit-serial multiply by the per-mille constant; hist holds the earlier busy
  // bits, the most recent in hist[0].
  always_comb begin
    msum = {1'b0, mul_c} + COL_W'(PER_MILLE[0] & bb);
    for (int k = 1; k < Q_W; k++) begin
      msum = msum + COL_W'(PER_MILLE[k] & hist[k-1]);
    end
  end

  // One restoring division step.
  always_comb begin
    r2   = {rem, qsh[Q_W-1]};
    rsub = r2 - {1'b0, den_sr};
    dge  = r2 >= {1'b0, den_sr};
  end

  // busy_b holds the final borrow: idle delta above total delta saturates.
  assign usage = busy_b ? ROUND_ADD : (qsh + ROUND_ADD);

  assign err_zeroed = (result.usage_tenths == '0) && (result.bar_level == '0);
  assign usage_ok   = (result.usage_tenths >= ROUND_ADD)
                   && (result.usage_tenths <= (PER_MILLE + ROUND_ADD))
                   && (result.bar_level != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        last_idle[s]  <= '0;
        last_total[s] <= '0;
      end
    end else begin
      if ((state == ST_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state      <= ST_SUM;
            cnt        <= '0;
            slot       <= sample.cpu_slot;
            in_range   <= slot_ok;
            ctr[0]     <= sample.user_time;
            ctr[1]     <= sample.nice_time;
            ctr[2]     <= sample.system_time;
            ctr[3]     <= sample.idle_time;
            ctr[4]     <= sample.iowait_time;
            ctr[5]     <= sample.irq_time;
            ctr[6]     <= sample.softirq_time;
            ctr[7]     <= sample.steal_time;
            old_idle   <= slot_ok ? last_idle[idx]  : '0;
            old_total  <= slot_ok ? last_total[idx] : '0;
            sum_c      <= '0;
            mul_c      <= '0;
            idle_b     <= 1'b0;
            tot_b      <= 1'b0;
            busy_b     <= 1'b0;
            hist       <= '0;
            nz         <= 1'b0;
          end
        end
        ST_SUM: begin
          cnt   <= (cnt == CNT_W'(PROD_W - 1)) ? '0 : cnt + CNT_W'(1);
          hist  <= {hist[Q_W-3:0], bb};
          mul_c <= msum[COL_W-1:1];
          prod  <= {msum[0], prod[PROD_W-1:1]};
          if (active) begin
            // counters rotate so they are whole again after the pass
            for (int i = 0; i < NUM_CTRS; i++) begin
              ctr[i] <= {ctr[i][0], ctr[i][CTR_W-1:1]};
            end
            old_idle   <= {1'b0, old_idle[CTR_W-1:1]};
            old_total  <= {1'b0, old_total[CTR_W-1:1]};
            total_sr   <= {tb, total_sr[CTR_W-1:1]};
            den_sr     <= {dt, den_sr[CTR_W-1:1]};
            sum_c      <= col[COL_W-1:1];
            idle_b     <= idle_b_next;
            tot_b      <= tot_b_next;
            busy_b     <= busy_b_next;
            nz         <= nz | dt;
          end
          if (cnt == CNT_W'(PROD_W - 1)) begin
            state <= ST_DIV;
            // quotient fits in Q_W bits, so the top of the product is
            // already below the divisor
            rem   <= {msum[0], prod[PROD_W-1:Q_W+1]};
            qsh   <= prod[Q_W:1];
            if (in_range) begin
              last_idle[slot[SLOT_IDX_W-1:0]]  <= ctr[IDLE_CTR];
              last_total[slot[SLOT_IDX_W-1:0]] <= total_sr;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt + CNT_W'(1);
          rem <= dge ? rsub[CTR_W-1:0] : r2[CTR_W-1:0];
          qsh <= {qsh[Q_W-2:0], dge};
          if (cnt == CNT_W'(Q_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result.slot_out      <= slot;
            result.no_time_error <= !nz;
            result.usage_tenths  <= nz ? usage : '0;
            result.bar_level     <= nz ? bar_of(usage) : '0;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CUM_ASSERT_NXT(a_accept_starts, accept, state == ST_SUM, "accepted item did not start")
  `CUM_ASSERT_IMP(a_rem_below_den, (state == ST_DIV) && nz && !busy_b, rem < den_sr, "bad remainder")
  `CUM_ASSERT_IMP(a_err_zero, result_valid && result.no_time_error, err_zeroed, "error not zeroed")
  `CUM_ASSERT_IMP(a_usage_range, result_valid && !result.no_time_error, usage_ok, "usage out of range")

endmodule
